// ----- hdl/ist_pkg.sv -----
// shared constants and codes for the integer set table
package ist_pkg;

   localparam int OPCODE_W  = 2;
   localparam int ELEMENT_W = 32;
   localparam int SIZE_W    = 5;

   // request tdata: opcode, element, zero padding to whole bytes
   localparam int REQ_DATA_W = 40;
   // response tdata: was_present, status, set_size, zero padding
   localparam int RSP_DATA_W = 8;

   localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

   typedef logic [OPCODE_W-1:0]  opcode_type;
   typedef logic [ELEMENT_W-1:0] element_type;

endpackage

// ----- hdl/ist_slot_ram.sv -----
// slot memory: one write port, one registered read port
module ist_slot_ram #(
   parameter int DEPTH  = 16,
   parameter int WORD_W = 33
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WORD_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WORD_W-1:0]        rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/integer_set_table_top.sv -----
// integer set table: top level with scan sequencer and response register
//
// Keeps a set of distinct 32-bit integers in a memory of CAPACITY slots.
// Request channel (req_*): opcode and element; insert, remove or query.
// Response channel (rsp_*): one response per request with was_present,
// status (1 = insert refused, table full) and the set size afterwards.
// Each request scans every slot of the memory, one read per cycle on its
// single read port, then goes through a state for the last read word
// (ST_LAST) and a write-back state (ST_COMMIT); the response register is
// loaded at write-back. A new request is taken only after the write-back,
// once the block is back in its idle state.
// Only one request is in progress at a time.
// After reset the block clears the memory, one slot per cycle, with
// req_tready low until every slot is cleared; the set is then empty.
// The response sits in an output register, so the next request is accepted
// and scanned while the previous response still waits; if the receiver
// stalls longer, the block holds at write-back until the register frees.
module integer_set_table_top #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [1:0] opcode, [33:2] element, [39:34] zero
   input  logic [ist_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [0] was_present, [1] status, [6:2] set_size, [7] zero
   output logic [ist_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int WORD_W = ist_pkg::ELEMENT_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_LAST   = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [IDX_W-1:0]          addr_ff, addr_in;
   logic                      rd_pend_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   ist_pkg::opcode_type       op_ff;
   ist_pkg::element_type      elem_ff;
   logic                      hit_ff, hit_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   logic                      free_ff, free_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ist_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic                      req_fire;
   logic [WORD_W-1:0]         rd_word;
   logic                      slot_live, match, empty;
   logic                      commit_go, do_ins, do_rem, full_refuse;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [WORD_W-1:0]         wr_data;
   logic [CNT_W+ist_pkg::SIZE_W-1:0] count_ext;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   ist_slot_ram #(
      .DEPTH  (CAPACITY),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_word)
   );

   // compare the word that came back from the previous read
   assign slot_live = rd_word[WORD_W-1];
   assign match = rd_pend_ff && slot_live &&
                  (rd_word[ist_pkg::ELEMENT_W-1:0] == elem_ff);
   assign empty = rd_pend_ff && !slot_live;

   always_comb begin
      hit_in      = hit_ff || match;
      hit_idx_in  = match ? rd_idx_ff : hit_idx_ff;
      free_in     = free_ff || empty;
      free_idx_in = (empty && !free_ff) ? rd_idx_ff : free_idx_ff;
      if (req_fire) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end
   end

   assign commit_go   = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_tready);
   assign do_ins      = (op_ff == ist_pkg::OP_INSERT) && !hit_ff && free_ff;
   assign do_rem      = (op_ff == ist_pkg::OP_REMOVE) && hit_ff;
   assign full_refuse = (op_ff == ist_pkg::OP_INSERT) && !hit_ff && !free_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
      end else if (commit_go && (do_ins || do_rem)) begin
         wr_en   = 1'b1;
         wr_addr = do_ins ? free_idx_ff : hit_idx_ff;
         wr_data = {do_ins, elem_ff};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (commit_go && do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (commit_go && do_rem) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_ext = {{ist_pkg::SIZE_W{1'b0}}, count_in};

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + IDX_W'(1);
            if (addr_ff == LAST_IDX) begin
               addr_in  = '0;
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= (state_ff == ST_SCAN);
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= addr_ff;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (req_fire) begin
         op_ff   <= req_tdata[ist_pkg::OPCODE_W-1:0];
         elem_ff <= req_tdata[ist_pkg::OPCODE_W +: ist_pkg::ELEMENT_W];
      end
      if (commit_go) begin
         rsp_data_ff <= {1'b0, count_ext[ist_pkg::SIZE_W-1:0], full_refuse, hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/ist_checker.sv -----
// port-level checks for the integer set table, bound to the top level
module ist_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [ist_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ist_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // memory clearing keeps requests out right after reset
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request ready right after reset");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // one request at a time: the scan starts at once
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request taken while scanning");

   // a refused insert never reports the element as present
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("full status with element present");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind integer_set_table_top ist_checker u_ist_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- test/integer_set_table_top_test.sv -----
// self-checking testbench for the integer set table top level
module integer_set_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 16;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int RANDOM_ITEMS = 1800;
   localparam int QUIET_ITEMS  = 200;
   localparam int POOL_SIZE    = 24;
   localparam ist_pkg::opcode_type OP_UNUSED = 2'd3;

   typedef struct packed {
      logic                       was_present;
      logic                       status;
      logic [ist_pkg::SIZE_W-1:0] set_size;
   } set_answer_type;

   typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } traffic_mode_type;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [ist_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [ist_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the table
   bit                   slot_used [CAPACITY];
   ist_pkg::element_type slot_elem [CAPACITY];
   int                   members = 0;

   set_answer_type       pending_answers[$];
   ist_pkg::element_type value_pool [POOL_SIZE];
   int                   error_count       = 0;
   int                   cycle_count       = 0;
   int                   long_hold_request = 0;
   bit                   gaps_on           = 1'b1;
   bit                   stalls_on         = 1'b1;

   integer_set_table_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #4 clock = ~clock;

   // updates the shadow table and returns the response it implies
   function automatic set_answer_type apply_set_op(ist_pkg::opcode_type op,
                                                   ist_pkg::element_type elem);
      set_answer_type ans;
      int             hit;
      int             free_slot;
      hit       = -1;
      free_slot = -1;
      // walk downward so free_slot ends on the lowest free entry
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (slot_used[i] && slot_elem[i] == elem) hit = i;
         if (!slot_used[i]) free_slot = i;
      end
      ans.was_present = (hit >= 0);
      ans.status      = 1'b0;
      case (op)
         ist_pkg::OP_INSERT: begin
            if (hit < 0) begin
               if (free_slot >= 0) begin
                  slot_used[free_slot] = 1'b1;
                  slot_elem[free_slot] = elem;
                  members++;
               end else begin
                  ans.status = 1'b1;
               end
            end
         end
         ist_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               slot_used[hit] = 1'b0;
               members--;
            end
         end
         default: begin
         end
      endcase
      ans.set_size = ist_pkg::SIZE_W'(members);
      return ans;
   endfunction

   // a random current member, or a random value when the set is empty
   function automatic ist_pkg::element_type pick_member();
      int idx[$];
      foreach (slot_used[i]) if (slot_used[i]) idx.push_back(i);
      if (idx.size() == 0) return $urandom;
      return slot_elem[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   // leaves req_tvalid high so back-to-back requests need no second assignment
   task automatic send_request(input ist_pkg::opcode_type op,
                               input ist_pkg::element_type elem);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 4);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ist_pkg::REQ_DATA_W - ist_pkg::OPCODE_W - ist_pkg::ELEMENT_W){1'b0}},
                     elem, op};
      do @(posedge clock); while (!req_tready);
      pending_answers.push_back(apply_set_op(op, elem));
   endtask

   task automatic wait_all_answered();
      req_tvalid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(ist_pkg::OP_QUERY,  32'h0000_0000);
      send_request(ist_pkg::OP_REMOVE, 32'h0000_0000);
      send_request(ist_pkg::OP_INSERT, 32'h8000_0000);
      send_request(ist_pkg::OP_INSERT, 32'h7fff_ffff);
      send_request(ist_pkg::OP_INSERT, 32'h0000_0000);
      send_request(ist_pkg::OP_INSERT, 32'hffff_ffff);
      // duplicate insert leaves the set alone
      send_request(ist_pkg::OP_INSERT, 32'h8000_0000);
      send_request(ist_pkg::OP_QUERY,  32'h7fff_ffff);
      send_request(ist_pkg::OP_QUERY,  32'h0000_0001);
      send_request(OP_UNUSED,          32'hffff_ffff);
      send_request(OP_UNUSED,          32'h5555_aaaa);
      send_request(ist_pkg::OP_REMOVE, 32'h0000_3039);
      send_request(ist_pkg::OP_REMOVE, 32'h0000_0000);
      send_request(ist_pkg::OP_QUERY,  32'h0000_0000);
      send_request(ist_pkg::OP_INSERT, 32'haaaa_5555);
      send_request(ist_pkg::OP_REMOVE, 32'hffff_ffff);
      send_request(ist_pkg::OP_REMOVE, 32'h8000_0000);
      send_request(ist_pkg::OP_REMOVE, 32'h7fff_ffff);
      send_request(ist_pkg::OP_REMOVE, 32'haaaa_5555);
      send_request(ist_pkg::OP_QUERY,  32'h8000_0000);
   endtask

   task automatic test_full_table();
      ist_pkg::element_type held[$];
      wait_all_answered();
      while (members < CAPACITY) send_request(ist_pkg::OP_INSERT, $urandom);
      send_request(ist_pkg::OP_INSERT, $urandom);
      send_request(ist_pkg::OP_INSERT, pick_member());
      send_request(ist_pkg::OP_QUERY,  pick_member());
      send_request(OP_UNUSED,          pick_member());
      send_request(ist_pkg::OP_REMOVE, $urandom);
      send_request(ist_pkg::OP_REMOVE, pick_member());
      send_request(ist_pkg::OP_INSERT, $urandom);
      send_request(ist_pkg::OP_INSERT, $urandom);
      foreach (slot_used[i]) if (slot_used[i]) held.push_back(slot_elem[i]);
      foreach (held[i]) send_request(ist_pkg::OP_REMOVE, held[i]);
      send_request(ist_pkg::OP_REMOVE, $urandom);
      send_request(ist_pkg::OP_QUERY,  $urandom);
   endtask

   // receiver holds off while requests keep coming, so the block backs up
   task automatic test_backpressure();
      long_hold_request = 200;
      repeat (12) send_request(($urandom_range(0, 1) == 0) ? ist_pkg::OP_INSERT
                                                           : ist_pkg::OP_REMOVE,
                               value_pool[$urandom_range(0, POOL_SIZE - 1)]);
   endtask

   task automatic test_random();
      traffic_mode_type     mode;
      int                   ins_share;
      int                   r;
      int                   s;
      ist_pkg::opcode_type  op;
      ist_pkg::element_type elem;
      mode = MODE_MIXED;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) mode = traffic_mode_type'($urandom_range(0, 2));
         if (n % 400 == 399) wait_all_answered();
         if (n == 900) long_hold_request = 150;
         if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end
         case (mode)
            MODE_FILL:  ins_share = 60;
            MODE_DRAIN: ins_share = 16;
            default:    ins_share = 36;
         endcase
         r = $urandom_range(0, 99);
         if (r < 5) op = OP_UNUSED;
         else if (r < 20) op = ist_pkg::OP_QUERY;
         else if (r < 20 + ins_share) op = ist_pkg::OP_INSERT;
         else op = ist_pkg::OP_REMOVE;
         s = $urandom_range(0, 9);
         if (op == ist_pkg::OP_INSERT) begin
            elem = (s < 7) ? value_pool[$urandom_range(0, POOL_SIZE - 1)] : $urandom;
         end else begin
            if (s < 5) elem = pick_member();
            else if (s < 8) elem = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else elem = $urandom;
         end
         send_request(op, elem);
      end
   endtask

   // response receiver: random short stalls plus requested long hold-offs
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (long_hold_request > 0) begin
            hold_left         = long_hold_request;
            long_hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            hold_left  = $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      set_answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $error("response with no request outstanding: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[0] !== want.was_present) begin
               $error("was_present: expected %0d, actual %0d", want.was_present,
                      rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[1] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1]);
               error_count++;
            end
            if (rsp_tdata[2 +: ist_pkg::SIZE_W] !== want.set_size) begin
               $error("set_size: expected %0d, actual %0d", want.set_size,
                      rsp_tdata[2 +: ist_pkg::SIZE_W]);
               error_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7fff_ffff;
      value_pool[2] = 32'h0000_0000;
      value_pool[3] = 32'hffff_ffff;
      value_pool[4] = 32'h0000_0001;
      value_pool[5] = 32'h8000_0001;
      for (int i = 6; i < POOL_SIZE; i++) value_pool[i] = $urandom;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_table();
      test_backpressure();
      test_random();
      wait_all_answered();
      repeat (CAPACITY + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/ist_pkg.sv
hdl/ist_slot_ram.sv
hdl/integer_set_table_top.sv
hdl/ist_checker.sv
test/integer_set_table_top_test.sv
